### rtl/bfd_pkg.sv
`default_nettype none
package bfd_pkg;

  localparam int SAMPLE_COUNT_BITS   = 22;
  localparam int RATIO_FRACTION_BITS = 8;

  localparam int CNT_W   = SAMPLE_COUNT_BITS + 2;
  localparam int RSUM_W  = SAMPLE_COUNT_BITS + 8 + RATIO_FRACTION_BITS;
  localparam int RCNT_W  = SAMPLE_COUNT_BITS + 1;
  localparam int QW      = 8 + RATIO_FRACTION_BITS;   // quotient bits
  localparam int NUM_W   = 17 + RATIO_FRACTION_BITS;  // 255*n << frac
  localparam int QCW     = $clog2(QW);
  localparam int DIFF_W  = 8;
  localparam int NOISE_W = 23;
  localparam int PIX_W   = 25;
  localparam int THR_W   = NOISE_W + PIX_W;
  localparam int PCT_W   = CNT_W + THR_W + 1;
  localparam int MET_W   = RCNT_W + 8 + RATIO_FRACTION_BITS + 1;
  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [DIFF_W-1:0]  DIFF_RESET  = DIFF_W'(5);
  localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(1966);
  localparam logic [PIX_W-1:0]   PIX_RESET   = PIX_W'(345600);

  localparam logic [1:0] REG_DIFF  = 2'd0;
  localparam logic [1:0] REG_NOISE = 2'd1;
  localparam logic [1:0] REG_PIX   = 2'd2;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_MISS
  } res_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_DEC
  } back_state_e;

  typedef struct packed {
    logic [7:0] frame0_upper;
    logic [7:0] frame0_lower;
    logic [7:0] frame1_upper;
    logic [7:0] frame1_lower;
    logic [7:0] frame2_upper;
    logic [7:0] frame2_lower;
    logic [7:0] frame3_upper;
    logic [7:0] frame3_lower;
    logic [7:0] frame4_upper;
    logic [7:0] frame4_lower;
    logic       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] blend_direction;
    logic              blended;
  } out_item_t;

  // classified sample passed from front to back
  typedef struct packed {
    res_e       res_prev;
    res_e       res_mid;
    res_e       res_next;
    logic [8:0] num_mid;
    logic [8:0] den_mid;
    logic       last;
  } entry_t;

endpackage
`default_nettype wire

### rtl/bfd_front.sv
`default_nettype none
module bfd_front (
  input  var bfd_pkg::in_item_t          item_i,
  input  var logic [bfd_pkg::DIFF_W-1:0] diff_thr_i,
  output var bfd_pkg::entry_t            entry_o
);

  typedef struct packed {
    bfd_pkg::res_e res;
    logic [8:0]    num;
    logic [8:0]    den;
  } tri_t;

  // window test of one frame triple by cross products
  function automatic tri_t test_tri(input logic [8:0] sa, input logic [8:0] sm,
                                    input logic [8:0] sb, input logic [7:0] thr);
    logic signed [9:0]  d;
    logic signed [9:0]  n;
    logic signed [9:0]  dn;
    logic signed [9:0]  nn;
    logic [8:0]         ad;
    logic signed [19:0] p;
    logic signed [19:0] lo;
    logic signed [19:0] hi;
    tri_t               r;
    d  = $signed({1'b0, sb}) - $signed({1'b0, sa});
    n  = $signed({1'b0, sm}) - $signed({1'b0, sa});
    dn = d[9] ? -d : d;
    nn = d[9] ? -n : n;
    ad = dn[8:0];
    p  = (20'(nn) <<< 8) - 20'(nn);
    lo = 20'(dn) <<< 5;
    hi = (20'(dn) <<< 8) - (20'(dn) <<< 5);
    r.num = nn[8:0];
    r.den = dn[8:0];
    if (ad <= {thr, 1'b0}) begin
      r.res = bfd_pkg::RES_NONE;
    end else if (p > lo && p < hi) begin
      r.res = bfd_pkg::RES_HIT;
    end else begin
      r.res = bfd_pkg::RES_MISS;
    end
    return r;
  endfunction

  logic [8:0] s0, s1, s2, s3, s4;
  tri_t       t_prev, t_mid, t_next;

  // pair sums
  assign s0 = {1'b0, item_i.frame0_upper} + {1'b0, item_i.frame0_lower};
  assign s1 = {1'b0, item_i.frame1_upper} + {1'b0, item_i.frame1_lower};
  assign s2 = {1'b0, item_i.frame2_upper} + {1'b0, item_i.frame2_lower};
  assign s3 = {1'b0, item_i.frame3_upper} + {1'b0, item_i.frame3_lower};
  assign s4 = {1'b0, item_i.frame4_upper} + {1'b0, item_i.frame4_lower};

  // classify the three triples
  always_comb begin
    t_prev = test_tri(s0, s1, s2, diff_thr_i);
    t_mid  = test_tri(s1, s2, s3, diff_thr_i);
    t_next = test_tri(s2, s3, s4, diff_thr_i);
    entry_o.res_prev = t_prev.res;
    entry_o.res_mid  = t_mid.res;
    entry_o.res_next = t_next.res;
    entry_o.num_mid  = t_mid.num;
    entry_o.den_mid  = t_mid.den;
    entry_o.last     = item_i.last_sample;
  end

endmodule
`default_nettype wire

### rtl/bfd_queue.sv
`default_nettype none
module bfd_queue (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var logic            push_i,
  input  var bfd_pkg::entry_t data_i,
  output var logic            full_o,
  input  var logic            pop_i,
  output var logic            empty_o,
  output var bfd_pkg::entry_t data_o
);

  bfd_pkg::entry_t                mem_q [bfd_pkg::QDEPTH];
  logic [bfd_pkg::QAW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [bfd_pkg::QAW:0]          cnt_q, cnt_d;

  assign full_o  = (cnt_q == (bfd_pkg::QAW+1)'(bfd_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == bfd_pkg::QAW'(bfd_pkg::QDEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == bfd_pkg::QAW'(bfd_pkg::QDEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/bfd_back.sv
`default_nettype none
module bfd_back (
  input  var logic                        clk_i,
  input  var logic                        rst_ni,
  input  var logic                        empty_i,
  input  var bfd_pkg::entry_t             entry_i,
  output var logic                        pop_o,
  input  var logic [bfd_pkg::THR_W-1:0]   thr_i,
  output var logic                        out_valid_o,
  input  var logic                        out_stall_i,
  output var bfd_pkg::out_item_t          out_item_o
);

  bfd_pkg::back_state_e              state_q, state_d;
  bfd_pkg::entry_t                   ent_q;
  logic [bfd_pkg::NUM_W-1:0]         rem_q, rem_d;
  logic [bfd_pkg::NUM_W-1:0]         dsh_q, dsh_d;
  logic [bfd_pkg::QW-1:0]            quo_q, quo_d;
  logic [bfd_pkg::QCW-1:0]           step_q, step_d;
  logic [bfd_pkg::CNT_W-1:0]         cnt_prev_q, cnt_mid_q, cnt_next_q;
  logic [bfd_pkg::RSUM_W-1:0]        rsum_q;
  logic [bfd_pkg::RCNT_W-1:0]        rcnt_q;
  logic signed [1:0]                 dec_q, dec_d;
  logic                              out_valid_q;
  bfd_pkg::out_item_t                out_q;
  logic                              out_free;
  logic                              do_pop, do_acc, do_dec;
  logic                              blended;
  logic                              trial_ok;
  logic [bfd_pkg::NUM_W-1:0]         trial;
  logic signed [bfd_pkg::PCT_W-1:0]  rhs;
  logic signed [bfd_pkg::PCT_W-1:0]  p_prev, p_mid, p_next;
  logic [bfd_pkg::MET_W-1:0]         m_lo, m_mid, m_hi, m_sum;

  // count times 200*65536 as shift and add
  function automatic logic signed [bfd_pkg::PCT_W-1:0] pct(
      input logic [bfd_pkg::CNT_W-1:0] c);
    logic signed [bfd_pkg::PCT_W-1:0] v;
    v = bfd_pkg::PCT_W'($signed(c));
    return ((v <<< 7) + (v <<< 6) + (v <<< 3)) <<< 16;
  endfunction

  function automatic logic [bfd_pkg::CNT_W-1:0] cnt_upd(
      input logic [bfd_pkg::CNT_W-1:0] c, input bfd_pkg::res_e r);
    logic [bfd_pkg::CNT_W-1:0] v;
    case (r)
      bfd_pkg::RES_HIT:  v = c + 1'b1;
      bfd_pkg::RES_MISS: v = c - 1'b1;
      default:           v = c;
    endcase
    return v;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign trial    = rem_q - dsh_q;
  assign trial_ok = (rem_q >= dsh_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfd_pkg::ST_IDLE: begin
        if (!empty_i) begin
          state_d = (entry_i.res_mid == bfd_pkg::RES_HIT) ? bfd_pkg::ST_DIV
                                                           : bfd_pkg::ST_ACC;
        end
      end
      bfd_pkg::ST_DIV: begin
        if (step_q == '0) state_d = bfd_pkg::ST_ACC;
      end
      bfd_pkg::ST_ACC: begin
        state_d = ent_q.last ? bfd_pkg::ST_DEC : bfd_pkg::ST_IDLE;
      end
      bfd_pkg::ST_DEC: begin
        if (out_free) state_d = bfd_pkg::ST_IDLE;
      end
      default: state_d = bfd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    do_pop = 1'b0;
    do_acc = 1'b0;
    do_dec = 1'b0;
    case (state_q)
      bfd_pkg::ST_IDLE: do_pop = !empty_i;
      bfd_pkg::ST_ACC:  do_acc = 1'b1;
      bfd_pkg::ST_DEC:  do_dec = out_free;
      default: ;
    endcase
  end
  assign pop_o = do_pop;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (do_pop) begin
      rem_d  = ((bfd_pkg::NUM_W'(entry_i.num_mid) << 8) - bfd_pkg::NUM_W'(entry_i.num_mid))
               << bfd_pkg::RATIO_FRACTION_BITS;
      dsh_d  = bfd_pkg::NUM_W'(entry_i.den_mid) << (bfd_pkg::QW-1);
      quo_d  = '0;
      step_d = bfd_pkg::QCW'(bfd_pkg::QW-1);
    end else if (state_q == bfd_pkg::ST_DIV) begin
      if (trial_ok) rem_d = trial;
      quo_d  = {quo_q[bfd_pkg::QW-2:0], trial_ok};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - 1'b1;
    end
  end

  // decision terms
  always_comb begin
    rhs    = bfd_pkg::PCT_W'(thr_i);
    p_prev = pct(cnt_prev_q);
    p_mid  = pct(cnt_mid_q);
    p_next = pct(cnt_next_q);
    blended = (p_mid > rhs) && (p_prev < rhs) && (p_next < rhs);
    m_lo  = bfd_pkg::MET_W'(rcnt_q) << (5 + bfd_pkg::RATIO_FRACTION_BITS);
    m_mid = bfd_pkg::MET_W'(rcnt_q) << (7 + bfd_pkg::RATIO_FRACTION_BITS);
    m_hi  = (bfd_pkg::MET_W'(rcnt_q) << (8 + bfd_pkg::RATIO_FRACTION_BITS)) - m_lo;
    m_sum = bfd_pkg::MET_W'(rsum_q);
    dec_d = dec_q;
    if (!blended) begin
      dec_d = 2'sd0;
    end else if (m_sum < m_mid && m_sum > m_lo) begin
      dec_d = -2'sd1;
    end else if (m_sum > m_mid && m_sum < m_hi) begin
      dec_d = 2'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfd_pkg::ST_IDLE;
      cnt_prev_q  <= '0;
      cnt_mid_q   <= '0;
      cnt_next_q  <= '0;
      rsum_q      <= '0;
      rcnt_q      <= bfd_pkg::RCNT_W'(1);
      dec_q       <= 2'sd0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      // accumulate one classified sample
      if (do_acc) begin
        cnt_prev_q <= cnt_upd(cnt_prev_q, ent_q.res_prev);
        cnt_mid_q  <= cnt_upd(cnt_mid_q, ent_q.res_mid);
        cnt_next_q <= cnt_upd(cnt_next_q, ent_q.res_next);
        if (ent_q.res_mid == bfd_pkg::RES_HIT) begin
          rsum_q <= rsum_q + bfd_pkg::RSUM_W'(quo_q);
          rcnt_q <= rcnt_q + 1'b1;
        end
      end
      // decide and clear accumulators
      if (do_dec) begin
        dec_q      <= dec_d;
        cnt_prev_q <= '0;
        cnt_mid_q  <= '0;
        cnt_next_q <= '0;
        rsum_q     <= '0;
        rcnt_q     <= bfd_pkg::RCNT_W'(1);
      end
      if (do_dec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    if (do_pop) ent_q <= entry_i;
    if (do_dec) begin
      out_q.blend_direction <= dec_d;
      out_q.blended         <= blended;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

### rtl/blend_frame_detector_unit.sv
// flow: the queue registers each accepted item; the back part pops it when
//   idle, divides the centre ratio bit-serially when the centre triple hits,
//   accumulates it, and on the last item of a frame decides and registers
//   the result; the back part takes one item at a time through the single
//   bit-serial divider, while the queue holds further items until full
// reset: asynchronous active low; state and configuration registers reset,
//   accumulators clear and the decision returns to zero
`default_nettype none
module blend_frame_detector_unit (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               in_valid_i,
  output var logic               in_stall_o,
  input  var bfd_pkg::in_item_t  in_item_i,
  output var logic               out_valid_o,
  input  var logic               out_stall_i,
  output var bfd_pkg::out_item_t out_item_o,
  input  var logic               psel,
  input  var logic               penable,
  input  var logic               pwrite,
  input  var logic [3:0]         paddr,
  input  var logic [31:0]        pwdata,
  output var logic [31:0]        prdata,
  output var logic               pready
);

  logic [bfd_pkg::DIFF_W-1:0]  diff_q;
  logic [bfd_pkg::NOISE_W-1:0] noise_q;
  logic [bfd_pkg::PIX_W-1:0]   pix_q;
  logic [bfd_pkg::THR_W-1:0]   thr_q;
  logic                        cfg_wr;
  logic                        full, empty, pop, push;
  bfd_pkg::entry_t             f_entry, q_entry;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q  <= bfd_pkg::DIFF_RESET;
      noise_q <= bfd_pkg::NOISE_RESET;
      pix_q   <= bfd_pkg::PIX_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bfd_pkg::REG_DIFF:  diff_q  <= pwdata[bfd_pkg::DIFF_W-1:0];
        bfd_pkg::REG_NOISE: noise_q <= pwdata[bfd_pkg::NOISE_W-1:0];
        bfd_pkg::REG_PIX:   pix_q   <= pwdata[bfd_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bfd_pkg::REG_DIFF:  prdata = 32'(diff_q);
      bfd_pkg::REG_NOISE: prdata = 32'(noise_q);
      bfd_pkg::REG_PIX:   prdata = 32'(pix_q);
      default:            prdata = '0;
    endcase
  end

  // threshold product, settles while the block is idle
  always_ff @(posedge clk_i) begin
    thr_q <= bfd_pkg::THR_W'(noise_q) * bfd_pkg::THR_W'(pix_q);
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  bfd_front u_front (
    .item_i     (in_item_i),
    .diff_thr_i (diff_q),
    .entry_o    (f_entry)
  );

  bfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_entry)
  );

  bfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .thr_i       (thr_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

### rtl/bfd_checker.sv
`default_nettype none
module bfd_checker (
  input var logic               clk_i,
  input var logic               rst_ni,
  input var logic               out_valid_o,
  input var logic               out_stall_i,
  input var bfd_pkg::out_item_t out_item_o
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // direction never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.blend_direction != 2'b10)
    else $error("bad blend direction");

  // a frame found not blended gives no direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.blended |-> out_item_o.blend_direction == 2'b00)
    else $error("direction without blend");

endmodule

bind blend_frame_detector_unit bfd_checker u_bfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
